// ===== hdl/swtn_pkg.sv =====
`timescale 1ns / 1ps
package swtn_pkg;

   localparam int JOINT_W    = 5;
   localparam int WEIGHT_W   = 16;
   localparam int NORM_W     = 17;
   localparam int CNT_OUT_W  = 3;
   localparam int OUT_SLOTS  = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 96;

   typedef struct packed {
      logic                valid;
      logic [JOINT_W-1:0]  joint;
      logic [WEIGHT_W-1:0] weight;
   } slot_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] min;
      logic                found;
      logic                prev_valid;
   } chain_type;

   typedef struct packed {
      logic                load;
      logic                clear;
      logic                full;
      logic [JOINT_W-1:0]  joint;
      logic [WEIGHT_W-1:0] weight;
      logic [WEIGHT_W-1:0] min;
   } cmd_type;

endpackage

// ===== hdl/swtn_cell.sv =====
`timescale 1ns / 1ps
module swtn_cell (
   input  logic                clock,
   input  logic                reset,
   input  swtn_pkg::cmd_type   cmd,
   input  swtn_pkg::chain_type fwd_in,
   output swtn_pkg::chain_type fwd_out,
   input  swtn_pkg::slot_type  nxt_in,
   output swtn_pkg::slot_type  slot_out
);

   logic                          valid_ff, valid_in;
   logic [swtn_pkg::JOINT_W-1:0]  joint_ff, joint_in;
   logic [swtn_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic                          hit;
   logic                          fill_here;

   assign hit       = cmd.full && (weight_ff == cmd.min) && !fwd_in.found;
   assign fill_here = !valid_ff && fwd_in.prev_valid;

   assign fwd_out.min        = (weight_ff < fwd_in.min) ? weight_ff : fwd_in.min;
   assign fwd_out.found      = fwd_in.found || hit;
   assign fwd_out.prev_valid = valid_ff;

   assign slot_out.valid  = valid_ff;
   assign slot_out.joint  = joint_ff;
   assign slot_out.weight = weight_ff;

   always_comb begin
      valid_in  = valid_ff;
      joint_in  = joint_ff;
      weight_in = weight_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.load) begin
         if (!cmd.full) begin
            if (fill_here) begin
               valid_in  = 1'b1;
               joint_in  = cmd.joint;
               weight_in = cmd.weight;
            end
         end else if (fwd_out.found) begin
            valid_in  = nxt_in.valid;
            joint_in  = nxt_in.joint;
            weight_in = nxt_in.weight;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      joint_ff  <= joint_in;
      weight_ff <= weight_in;
   end

endmodule

// ===== hdl/swtn_div.sv =====
`timescale 1ns / 1ps
module swtn_div #(
   parameter int SUM_W = 19
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [swtn_pkg::WEIGHT_W-1:0] dividend,
   input  logic [SUM_W-1:0]              divisor,
   output logic                          done,
   output logic [swtn_pkg::NORM_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(swtn_pkg::NORM_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [SUM_W:0]              rem_ff, rem_in;
   logic [SUM_W-1:0]            div_ff, div_in;
   logic [swtn_pkg::NORM_W-1:0] quo_ff, quo_in;
   logic                        ge;
   logic [SUM_W:0]              diff;

   assign ge   = rem_ff >= {1'b0, div_ff};
   assign diff = ge ? (rem_ff - {1'b0, div_ff}) : rem_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = (SUM_W+1)'(dividend);
         div_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = {diff[SUM_W-1:0], 1'b0};
         quo_in  = {quo_ff[swtn_pkg::NORM_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(swtn_pkg::NORM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/skin_weight_top4_normalizer.sv =====
`timescale 1ns / 1ps
// A new request is accepted only in idle, after the cell row update for the previous one.
// A request marked last then waits for the response slot to be free and runs the
// shared 17-step restoring divider once per kept influence before the response shows.
// A vertex with no influences skips the divider; its response shows with a zero count.
// Reset (synchronous, active high) empties the cell row, count, sum and response.
module skin_weight_top4_normalizer #(
   parameter int MAX_INFLUENCES = 4,
   parameter int JOINT_SLOTS    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // joint_index [4:0], weight [20:5], zero [23:21]
   input  logic [swtn_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // index_0..index_3 [19:0], norm_0..norm_3 [87:20], influence_count [90:88], zero [95:91]
   output logic [swtn_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CNT_W  = $clog2(MAX_INFLUENCES + 1);
   localparam int SUM_W  = swtn_pkg::WEIGHT_W + CNT_W;
   localparam int SLOT_W = $clog2(swtn_pkg::OUT_SLOTS + 1);
   localparam int OSEL_W = $clog2(swtn_pkg::OUT_SLOTS);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_UPD       = 3'd1;
   localparam logic [2:0] ST_WAIT      = 3'd2;
   localparam logic [2:0] ST_DIV_START = 3'd3;
   localparam logic [2:0] ST_DIV_RUN   = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [swtn_pkg::JOINT_W-1:0]  joint_ff, joint_in;
   logic [swtn_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic                          last_ff, last_in;
   logic                          keep_ff, keep_in;
   logic [swtn_pkg::WEIGHT_W-1:0] min_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [swtn_pkg::JOINT_W-1:0]  idx_ff [swtn_pkg::OUT_SLOTS];
   logic [swtn_pkg::JOINT_W-1:0]  idx_in [swtn_pkg::OUT_SLOTS];
   logic [swtn_pkg::NORM_W-1:0]   norm_ff [swtn_pkg::OUT_SLOTS];
   logic [swtn_pkg::NORM_W-1:0]   norm_in [swtn_pkg::OUT_SLOTS];
   logic [swtn_pkg::CNT_OUT_W-1:0] cnt_ff, cnt_in;

   swtn_pkg::cmd_type   cmd;
   swtn_pkg::chain_type chain [MAX_INFLUENCES+1];
   swtn_pkg::slot_type  slots [MAX_INFLUENCES];
   swtn_pkg::slot_type  nxt   [MAX_INFLUENCES];
   swtn_pkg::slot_type  out_slot [swtn_pkg::OUT_SLOTS];
   logic [MAX_INFLUENCES-1:0] valid_vec;

   logic                          full;
   logic                          drop;
   logic                          req_fire;
   logic                          out_free;
   logic                          div_start;
   logic                          div_done;
   logic [swtn_pkg::NORM_W-1:0]   div_q;
   logic [CNT_W+2:0]              cnt_wide;
   swtn_pkg::slot_type            sel_slot;

   assign full      = count_ff == CNT_W'(MAX_INFLUENCES);
   assign drop      = full && (weight_ff < min_ff);
   assign req_tready = state_ff == ST_IDLE;
   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign cnt_wide  = (CNT_W+3)'(count_ff);
   assign sel_slot  = out_slot[slot_ff[OSEL_W-1:0]];
   assign div_start = (state_ff == ST_DIV_START) &&
                      (slot_ff < SLOT_W'(swtn_pkg::OUT_SLOTS)) && sel_slot.valid;

   assign cmd.load   = (state_ff == ST_UPD) && keep_ff && !drop;
   assign cmd.clear  = (state_ff == ST_DIV_START) && !div_start;
   assign cmd.full   = full;
   assign cmd.joint  = joint_ff;
   assign cmd.weight = weight_ff;
   assign cmd.min    = min_ff;

   assign chain[0].min        = '1;
   assign chain[0].found      = 1'b0;
   assign chain[0].prev_valid = 1'b1;

   for (genvar i = 0; i < MAX_INFLUENCES; i++) begin : g_cell
      if (i < MAX_INFLUENCES - 1) begin : g_mid
         assign nxt[i] = slots[i+1];
      end else begin : g_end
         assign nxt[i].valid  = 1'b1;
         assign nxt[i].joint  = joint_ff;
         assign nxt[i].weight = weight_ff;
      end
      assign valid_vec[i] = slots[i].valid;
      swtn_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .fwd_in   (chain[i]),
         .fwd_out  (chain[i+1]),
         .nxt_in   (nxt[i]),
         .slot_out (slots[i])
      );
   end

   for (genvar k = 0; k < swtn_pkg::OUT_SLOTS; k++) begin : g_out
      if (k < MAX_INFLUENCES) begin : g_used
         assign out_slot[k] = slots[k];
      end else begin : g_none
         assign out_slot[k] = '0;
      end
   end

   swtn_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sel_slot.weight),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      joint_in     = joint_ff;
      weight_in    = weight_ff;
      last_in      = last_ff;
      keep_in      = keep_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      idx_in       = idx_ff;
      norm_in      = norm_ff;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               joint_in  = req_tdata[swtn_pkg::JOINT_W-1:0];
               weight_in = req_tdata[swtn_pkg::JOINT_W +: swtn_pkg::WEIGHT_W];
               last_in   = req_tlast;
               keep_in   = (req_tdata[swtn_pkg::JOINT_W +: swtn_pkg::WEIGHT_W] != '0) &&
                           (32'(req_tdata[swtn_pkg::JOINT_W-1:0]) < JOINT_SLOTS);
               state_in  = ST_UPD;
            end
         end
         ST_UPD: begin
            if (cmd.load) begin
               if (full) begin
                  sum_in = sum_ff + SUM_W'(weight_ff) - SUM_W'(min_ff);
               end else begin
                  sum_in   = sum_ff + SUM_W'(weight_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            state_in = last_ff ? ST_WAIT : ST_IDLE;
         end
         ST_WAIT: begin
            if (out_free) begin
               for (int k = 0; k < swtn_pkg::OUT_SLOTS; k++) begin
                  idx_in[k]  = out_slot[k].valid ? out_slot[k].joint : '0;
                  norm_in[k] = '0;
               end
               cnt_in   = cnt_wide[swtn_pkg::CNT_OUT_W-1:0];
               slot_in  = '0;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            if (div_start) begin
               state_in = ST_DIV_RUN;
            end else begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
               sum_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               norm_in[slot_ff[OSEL_W-1:0]] = div_q;
               slot_in  = slot_ff + 1'b1;
               state_in = ST_DIV_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      joint_ff  <= joint_in;
      weight_ff <= weight_in;
      last_ff   <= last_in;
      keep_ff   <= keep_in;
      min_ff    <= chain[MAX_INFLUENCES].min;
      slot_ff   <= slot_in;
      idx_ff    <= idx_in;
      norm_ff   <= norm_in;
      cnt_ff    <= cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, cnt_ff,
                        norm_ff[3], norm_ff[2], norm_ff[1], norm_ff[0],
                        idx_ff[3], idx_ff[2], idx_ff[1], idx_ff[0]};

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_INFLUENCES))
      else $error("kept count above limit");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("cell valid bits disagree with kept count");

   a_div_sum: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (sum_ff != '0))
      else $error("divide started with zero sum");

   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DIV_START))
      else $error("response raised outside divide finish");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.clear))
      else $error("cell row loaded and cleared together");

endmodule
